// ===== design/sem_pkg.sv =====
package sem_pkg;

   localparam int MAX_LINE     = 1024;
   localparam int ADDR_W       = $clog2(MAX_LINE);
   localparam int DIM_W        = 11;
   localparam int PIX_W        = 8;
   localparam int ABS_W        = 10;
   localparam int SQ_W         = 20;
   localparam int SUM_W        = SQ_W + 1;
   localparam int ROOT_W       = 16;
   localparam int FIFO_DEPTH   = 8;
   localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W   = FIFO_PTR_W + 1;
   localparam int FRONT_SLOTS  = 4;
   localparam int SQRT_STAGES  = 4;
   localparam int CSR_IDX_W    = 2;

   localparam logic [DIM_W-1:0] DIM_MIN    = 11'd3;
   localparam logic [DIM_W-1:0] DIM_MAX    = 11'd1024;
   localparam logic [PIX_W-1:0] EDGE_CLAMP = 8'd255;
   localparam logic [ROOT_W-1:0] SQRT_TOP_BIT = 16'h4000;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;
   localparam csr_index_type REG_LINE_WIDTH   = 2'd0;
   localparam csr_index_type REG_FRAME_HEIGHT = 2'd1;

   typedef struct packed {
      logic              sat;
      logic [ROOT_W-1:0] sq;
      logic              fe;
   } sem_item_type;

   typedef struct packed {
      logic [ROOT_W-1:0] rem;
      logic [ROOT_W-1:0] root;
   } sqrt_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v < DIM_MIN) begin
         r = DIM_MIN;
      end else if (v > DIM_MAX) begin
         r = DIM_MAX;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // one digit of the restoring square root
   function automatic sqrt_type sqrt_step(input sqrt_type cur, input logic [3:0] idx);
      sqrt_type          nxt;
      logic [ROOT_W-1:0] bitv;
      logic [ROOT_W:0]   trial;
      bitv  = SQRT_TOP_BIT >> {idx, 1'b0};
      trial = {1'b0, cur.root} + {1'b0, bitv};
      if ({1'b0, cur.rem} >= trial) begin
         nxt.rem  = cur.rem - trial[ROOT_W-1:0];
         nxt.root = (cur.root >> 1) + bitv;
      end else begin
         nxt.rem  = cur.rem;
         nxt.root = cur.root >> 1;
      end
      return nxt;
   endfunction

endpackage

// ===== design/sem_ram.sv =====
module sem_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/sem_front.sv =====
module sem_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  logic [sem_pkg::PIX_W-1:0]       pixel,
   output logic                            full,
   input  logic                            csr_valid,
   input  sem_pkg::csr_index_type          csr_index,
   input  logic [sem_pkg::DIM_W-1:0]       csr_data,
   input  logic [sem_pkg::FIFO_CNT_W-1:0]  fifo_count,
   output logic                            item_push,
   output sem_pkg::sem_item_type           item
);

   localparam int PW = sem_pkg::PIX_W;
   localparam int AW = sem_pkg::ADDR_W;
   localparam int DW = sem_pkg::DIM_W;
   localparam int BW = sem_pkg::ABS_W;
   localparam int QW = sem_pkg::SQ_W;

   logic [DW-1:0] width_ff, width_in, height_ff, height_in;
   logic [AW-1:0] col_ff, col_in, row_ff, row_in;
   logic          restart, accept, last_col, last_row;

   logic          s1_valid_ff, s1_valid_in;
   logic [PW-1:0] s1_pixel_ff, s1_pixel_in;
   logic [AW-1:0] s1_col_ff, s1_col_in;
   logic          s1_res_ff, s1_res_in, s1_fe_ff, s1_fe_in;

   logic [2*PW-1:0] line_rd;
   logic [PW-1:0]   win_ff [9];
   logic [PW-1:0]   win_in [9];

   logic          abs_valid_ff, abs_valid_in, abs_fe_ff, abs_fe_in;
   logic [BW-1:0] ax_ff, ax_in, ay_ff, ay_in;
   logic [BW-1:0] xp, xn, yp, yn;

   logic          sq_valid_ff, sq_valid_in, sq_fe_ff, sq_fe_in;
   logic [QW-1:0] sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [sem_pkg::SUM_W-1:0] sum;

   assign full   = fifo_count >=
                   sem_pkg::FIFO_CNT_W'(sem_pkg::FIFO_DEPTH - sem_pkg::FRONT_SLOTS);
   assign accept = push && !full;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      restart   = 1'b0;
      if (csr_valid) begin
         unique case (csr_index)
            sem_pkg::REG_LINE_WIDTH: begin
               width_in = sem_pkg::clamp_dim(csr_data);
               restart  = 1'b1;
            end
            sem_pkg::REG_FRAME_HEIGHT: begin
               height_in = sem_pkg::clamp_dim(csr_data);
               restart   = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   assign last_col = {1'b0, col_ff} == (width_ff - DW'(1));
   assign last_row = {1'b0, row_ff} == (height_ff - DW'(1));

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + AW'(1);
         end else begin
            col_in = col_ff + AW'(1);
         end
      end
   end

   always_comb begin
      s1_valid_in = accept;
      s1_pixel_in = pixel;
      s1_col_in   = col_ff;
      s1_res_in   = (row_ff >= AW'(2)) && (col_ff >= AW'(2));
      s1_fe_in    = last_row && last_col;
   end

   sem_ram #(
      .WIDTH (2 * PW),
      .DEPTH (sem_pkg::MAX_LINE)
   ) u_lines (
      .clock (clock),
      .we    (s1_valid_ff),
      .waddr (s1_col_ff),
      .wdata ({line_rd[PW-1:0], s1_pixel_ff}),
      .raddr (col_ff),
      .rdata (line_rd)
   );

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         win_in[i] = win_ff[i];
      end
      if (s1_valid_ff) begin
         for (int r = 0; r < 3; r++) begin
            win_in[3*r]   = win_ff[3*r+1];
            win_in[3*r+1] = win_ff[3*r+2];
         end
         win_in[2] = line_rd[2*PW-1:PW];
         win_in[5] = line_rd[PW-1:0];
         win_in[8] = s1_pixel_ff;
      end
   end

   always_comb begin
      xp = {2'b00, win_in[2]} + {1'b0, win_in[5], 1'b0} + {2'b00, win_in[8]};
      xn = {2'b00, win_in[0]} + {1'b0, win_in[3], 1'b0} + {2'b00, win_in[6]};
      yp = {2'b00, win_in[6]} + {1'b0, win_in[7], 1'b0} + {2'b00, win_in[8]};
      yn = {2'b00, win_in[0]} + {1'b0, win_in[1], 1'b0} + {2'b00, win_in[2]};
      ax_in = (xp >= xn) ? xp - xn : xn - xp;
      ay_in = (yp >= yn) ? yp - yn : yn - yp;
      abs_valid_in = s1_valid_ff && s1_res_ff;
      abs_fe_in    = s1_fe_ff;
   end

   always_comb begin
      sqx_in      = QW'(ax_ff) * QW'(ax_ff);
      sqy_in      = QW'(ay_ff) * QW'(ay_ff);
      sq_valid_in = abs_valid_ff;
      sq_fe_in    = abs_fe_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= sem_pkg::DIM_MAX;
         height_ff    <= sem_pkg::DIM_MAX;
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         abs_valid_ff <= 1'b0;
         sq_valid_ff  <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         s1_valid_ff  <= s1_valid_in;
         abs_valid_ff <= abs_valid_in;
         sq_valid_ff  <= sq_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_pixel_ff <= s1_pixel_in;
      s1_col_ff   <= s1_col_in;
      s1_res_ff   <= s1_res_in;
      s1_fe_ff    <= s1_fe_in;
      for (int i = 0; i < 9; i++) begin
         win_ff[i] <= win_in[i];
      end
      ax_ff     <= ax_in;
      ay_ff     <= ay_in;
      abs_fe_ff <= abs_fe_in;
      sqx_ff    <= sqx_in;
      sqy_ff    <= sqy_in;
      sq_fe_ff  <= sq_fe_in;
   end

   assign sum       = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign item_push = sq_valid_ff;
   assign item.sat  = |sum[sem_pkg::SUM_W-1:sem_pkg::ROOT_W];
   assign item.sq   = sum[sem_pkg::ROOT_W-1:0];
   assign item.fe   = sq_fe_ff;

endmodule

// ===== design/sem_fifo.sv =====
module sem_fifo (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  sem_pkg::sem_item_type           wdata,
   input  logic                            pop,
   output sem_pkg::sem_item_type           rdata,
   output logic                            empty,
   output logic [sem_pkg::FIFO_CNT_W-1:0]  count
);

   localparam int PTR_W = sem_pkg::FIFO_PTR_W;
   localparam int CNT_W = sem_pkg::FIFO_CNT_W;

   sem_pkg::sem_item_type mem_ff [sem_pkg::FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   assign rdata = mem_ff[rd_ptr_ff];
   assign empty = count_ff == '0;
   assign count = count_ff;

endmodule

// ===== design/sem_back.sv =====
module sem_back (
   input  logic                        clock,
   input  logic                        reset,
   input  sem_pkg::sem_item_type       head,
   input  logic                        head_empty,
   output logic                        head_pop,
   output logic                        empty,
   input  logic                        pop,
   output logic [sem_pkg::PIX_W-1:0]   edge_res,
   output logic                        frame_end
);

   localparam int NS = sem_pkg::SQRT_STAGES;
   localparam int PW = sem_pkg::PIX_W;

   logic                adv;
   logic                st_valid_ff [NS];
   logic                st_valid_in [NS];
   sem_pkg::sqrt_type   st_val_ff [NS];
   sem_pkg::sqrt_type   st_val_in [NS];
   logic                st_sat_ff [NS];
   logic                st_sat_in [NS];
   logic                st_fe_ff [NS];
   logic                st_fe_in [NS];

   logic          out_valid_ff, out_valid_in, out_fe_ff, out_fe_in;
   logic [PW-1:0] out_res_ff, out_res_in;

   assign adv      = !out_valid_ff || pop;
   assign head_pop = adv && !head_empty;

   always_comb begin
      sem_pkg::sqrt_type src;
      for (int k = 0; k < NS; k++) begin
         if (k == 0) begin
            src.rem        = head.sq;
            src.root       = '0;
            st_valid_in[k] = !head_empty;
            st_sat_in[k]   = head.sat;
            st_fe_in[k]    = head.fe;
         end else begin
            src            = st_val_ff[k-1];
            st_valid_in[k] = st_valid_ff[k-1];
            st_sat_in[k]   = st_sat_ff[k-1];
            st_fe_in[k]    = st_fe_ff[k-1];
         end
         st_val_in[k] = sem_pkg::sqrt_step(sem_pkg::sqrt_step(src, 4'(2*k)), 4'(2*k+1));
      end
   end

   always_comb begin
      out_valid_in = st_valid_ff[NS-1];
      out_fe_in    = st_fe_ff[NS-1];
      out_res_in   = st_sat_ff[NS-1] ? sem_pkg::EDGE_CLAMP : st_val_ff[NS-1].root[PW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS; k++) begin
            st_valid_ff[k] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         for (int k = 0; k < NS; k++) begin
            st_valid_ff[k] <= st_valid_in[k];
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NS; k++) begin
            st_val_ff[k] <= st_val_in[k];
            st_sat_ff[k] <= st_sat_in[k];
            st_fe_ff[k]  <= st_fe_in[k];
         end
         out_res_ff <= out_res_in;
         out_fe_ff  <= out_fe_in;
      end
   end

   assign empty     = !out_valid_ff;
   assign edge_res  = out_res_ff;
   assign frame_end = out_fe_ff;

endmodule

// ===== design/sobel_edge_magnitude.sv =====
// Sobel 3x3 edge magnitude over a raster-order stream of 8-bit pixels.
// Input queue: drive req_pixel and push; the item is taken on a clock edge
// with push high and full low. Result queue: while empty is low the oldest
// result sits on rsp_edge_res / rsp_frame_end; pop takes it. Only interior
// pixels give a result (one per pixel from row 2, column 2 on, for the
// window centered one row and one column back); rsp_frame_end marks the
// last one of a frame.
// CSR port: valid/ready (ready always high), csr_index 0 = line width,
// 1 = frame height, values clamped to 3..1024. A write to either
// of them restarts the frame counters; write only while no item is in flight.
// Throughput: one pixel per cycle while results are popped. From accepting
// a pixel, its result passes three front stages (line store read, window
// and gradients, squares), one queue write and a four-stage square-root
// pipeline of two root bits per stage, then the result register. When
// pop stays low the root pipeline holds, the 8-entry queue fills and full
// rises with four slots kept for items still in the front stages. Reset
// sets both dimensions to 1024, the counters to zero and drops all items
// in flight; the line stores need no clearing.
module sobel_edge_magnitude (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic [sem_pkg::PIX_W-1:0]    req_pixel,
   output logic                         full,
   output logic                         empty,
   input  logic                         pop,
   output logic [sem_pkg::PIX_W-1:0]    rsp_edge_res,
   output logic                         rsp_frame_end,
   input  logic                         valid,
   output logic                         ready,
   input  sem_pkg::csr_index_type       csr_index,
   input  logic [sem_pkg::DIM_W-1:0]    csr_data
);

   logic                                fifo_push, fifo_pop, fifo_empty;
   sem_pkg::sem_item_type               fifo_wdata, fifo_rdata;
   logic [sem_pkg::FIFO_CNT_W-1:0]      fifo_count;

   assign ready = 1'b1;

   sem_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pixel      (req_pixel),
      .full       (full),
      .csr_valid  (valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fifo_count (fifo_count),
      .item_push  (fifo_push),
      .item       (fifo_wdata)
   );

   sem_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (fifo_push),
      .wdata (fifo_wdata),
      .pop   (fifo_pop),
      .rdata (fifo_rdata),
      .empty (fifo_empty),
      .count (fifo_count)
   );

   sem_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (fifo_rdata),
      .head_empty (fifo_empty),
      .head_pop   (fifo_pop),
      .empty      (empty),
      .pop        (pop),
      .edge_res   (rsp_edge_res),
      .frame_end  (rsp_frame_end)
   );

endmodule
